@@ sv/clb_pkg.sv @@
// Package for the C comment and literal blanker.
// Holds character codes, scan mode and result types, and the byte scan function.
// Used by clb_out_buf and the top level; depends on nothing.
`default_nettype none

package clb_pkg;

  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharSquote = 8'h27;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharNone   = 8'h00;

  // Scanning modes carried from byte to byte
  typedef struct packed {
    logic in_block;
    logic in_str;
    logic in_chr;
    logic esc;
    logic in_line;
  } modes_t;

  // Outcome of examining one byte
  typedef struct packed {
    logic [7:0] ch;
    logic       took;
    modes_t     m;
  } scan_t;

  // One result item
  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
    logic       run_last;
    logic       block_open;
  } result_t;

  // Results produced by one accepted request, packed from slot a
  typedef struct packed {
    logic [1:0] n;
    result_t    a;
    result_t    b;
  } push_t;

  // Examine byte b with lookahead la; has_la low means end of line
  function automatic scan_t scan_byte(modes_t m, logic [7:0] b, logic [7:0] la,
                                      logic has_la);
    scan_t s;
    s.ch   = CharSpace;
    s.took = 1'b0;
    s.m    = m;
    if (m.in_line) begin
      s.ch = CharSpace;
    end else if (m.in_block) begin
      if (b == CharStar && has_la && la == CharSlash) begin
        s.m.in_block = 1'b0;
        s.took       = 1'b1;
      end
    end else if (m.in_str || m.in_chr) begin
      if (m.esc) begin
        s.m.esc = 1'b0;
      end else if (b == CharBslash) begin
        s.m.esc = 1'b1;
      end else if ((m.in_str && b == CharDquote) || (!m.in_str && b == CharSquote)) begin
        s.m.in_str = 1'b0;
        s.m.in_chr = 1'b0;
      end
    end else if (b == CharSlash && has_la && la == CharStar) begin
      s.m.in_block = 1'b1;
      s.took       = 1'b1;
    end else if (b == CharSlash && has_la && la == CharSlash) begin
      s.m.in_line = 1'b1;
      s.took      = 1'b1;
    end else if (b == CharDquote) begin
      s.m.in_str = 1'b1;
    end else if (b == CharSquote) begin
      s.m.in_chr = 1'b1;
    end else begin
      s.ch = b;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ sv/clb_out_buf.sv @@
// Three-entry result queue of the C comment and literal blanker.
// Takes up to two results per request and releases one per cycle unless the output stalls; uses clb_pkg.
`default_nettype none

module clb_out_buf (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire clb_pkg::push_t push_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output clb_pkg::result_t    out_res_o
);

  logic [1:0]       count_q, count_d;
  clb_pkg::result_t ent_q [3];
  clb_pkg::result_t ent_d [3];
  clb_pkg::result_t shifted [3];
  logic             pop;
  logic [1:0]       base;

  assign out_valid_o = (count_q != 2'd0);
  assign out_res_o   = ent_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  // Stop requests while a pair could not fit
  assign full_o      = (count_q > 2'd1);

  // Drop the head on a pop, then append the new results behind the rest
  always_comb begin
    shifted[0] = pop ? ent_q[1] : ent_q[0];
    shifted[1] = pop ? ent_q[2] : ent_q[1];
    shifted[2] = ent_q[2];
    base       = count_q - {1'b0, pop};
    for (int i = 0; i < 3; i++) begin
      if (push_i.n != 2'd0 && 2'(i) == base) begin
        ent_d[i] = push_i.a;
      end else if (push_i.n == 2'd2 && 2'(i) == base + 2'd1) begin
        ent_d[i] = push_i.b;
      end else begin
        ent_d[i] = shifted[i];
      end
    end
    count_d = base + push_i.n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // Hold entries; payload needs no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

endmodule

`default_nettype wire

@@ sv/c_comment_literal_blanker_unit.sv @@
// Top level of the C comment and literal blanker.
// Holds the lookahead byte and scan modes; depends on clb_pkg and clb_out_buf.
//
// The block takes C source one byte per request and returns it with every byte of a
// comment, string or character literal turned into a space. Each byte leaves one
// request later, once the next byte is known as its lookahead; the last byte of a
// line leaves at once, together with the byte held before it. A new request is taken
// every cycle while the result queue is not full; a line end that releases two results
// puts both into a three-entry result queue, which stops requests while it drains.
// Output stall backs up into that queue and then into the input.
`default_nettype none

module c_comment_literal_blanker_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] char_in_i,
  input  wire        line_last_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] char_out_o,
  output logic       line_end_o,
  output logic       run_last_o,
  output logic       block_open_o
);

  logic [7:0]       held_byte_q, held_byte_d;
  logic             held_valid_q, held_valid_d;
  logic             held_took_q, held_took_d;
  clb_pkg::modes_t  modes_q, modes_d;
  clb_pkg::scan_t   s0, s1;
  clb_pkg::modes_t  m0, m1;
  logic [7:0]       r0_ch, r1_ch;
  logic             took0;
  logic             accept;
  logic             full;
  clb_pkg::push_t   push;
  clb_pkg::result_t res0, res1, out_res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Scan the held byte against the new byte, then the new byte at line end
  always_comb begin
    s0 = clb_pkg::scan_byte(modes_q, held_byte_q, char_in_i, 1'b1);
    if (!held_valid_q || held_took_q) begin
      r0_ch = clb_pkg::CharSpace;
      took0 = 1'b0;
      m0    = modes_q;
    end else begin
      r0_ch = s0.ch;
      took0 = s0.took;
      m0    = s0.m;
    end
    s1    = clb_pkg::scan_byte(m0, char_in_i, clb_pkg::CharNone, 1'b0);
    r1_ch = took0 ? clb_pkg::CharSpace : s1.ch;
    m1    = took0 ? m0 : s1.m;
  end

  // Build the results of this request
  always_comb begin
    res0.ch         = r0_ch;
    res0.line_end   = 1'b0;
    res0.run_last   = !line_last_i;
    res0.block_open = m0.in_block;
    res1.ch         = r1_ch;
    res1.line_end   = 1'b1;
    res1.run_last   = 1'b1;
    res1.block_open = m1.in_block;
    push.a = res0;
    push.b = res1;
    push.n = 2'd0;
    if (accept) begin
      if (held_valid_q && line_last_i) begin
        push.n = 2'd2;
      end else if (held_valid_q) begin
        push.n = 2'd1;
      end else if (line_last_i) begin
        push.a = res1;
        push.n = 2'd1;
      end
    end
  end

  // Advance the lookahead and modes; clear line modes at line end
  always_comb begin
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    held_took_d  = held_took_q;
    modes_d      = modes_q;
    if (accept) begin
      if (line_last_i) begin
        held_byte_d      = clb_pkg::CharNone;
        held_valid_d     = 1'b0;
        held_took_d      = 1'b0;
        modes_d          = '0;
        modes_d.in_block = m1.in_block;
      end else begin
        held_byte_d  = char_in_i;
        held_valid_d = 1'b1;
        held_took_d  = took0;
        modes_d      = m0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_byte_q  <= 8'h00;
      held_valid_q <= 1'b0;
      held_took_q  <= 1'b0;
      modes_q      <= '0;
    end else begin
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      held_took_q  <= held_took_d;
      modes_q      <= modes_d;
    end
  end

  clb_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign char_out_o   = out_res.ch;
  assign line_end_o   = out_res.line_end;
  assign run_last_o   = out_res.run_last;
  assign block_open_o = out_res.block_open;

endmodule

`default_nettype wire

@@ sv/clb_checker.sv @@
// Port-level checker for the C comment and literal blanker.
// Watches c_comment_literal_blanker_unit ports only; bound in at the end of this file.
`default_nettype none

module clb_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_stall_o,
  input wire [7:0] char_in_i,
  input wire       line_last_i,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire [7:0] char_out_o,
  input wire       line_end_o,
  input wire       run_last_o,
  input wire       block_open_o
);

  // A line's last byte always ends the run of its request
  a_line_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_end_o |-> run_last_o)
    else $error("line end result not marked as run last");

  // The first of a pair is followed at once by the line's last byte
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o && line_end_o)
    else $error("second result of a pair missing");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_out_o)
      && $stable(line_end_o) && $stable(run_last_o) && $stable(block_open_o))
    else $error("stalled result changed");

endmodule

bind c_comment_literal_blanker_unit clb_checker u_clb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .char_in_i    (char_in_i),
  .line_last_i  (line_last_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .char_out_o   (char_out_o),
  .line_end_o   (line_end_o),
  .run_last_o   (run_last_o),
  .block_open_o (block_open_o)
);

`default_nettype wire
